[src/imh_pkg.sv]
// ----------------------------------------------------------------------------
// imh_pkg: shared types and constants for the indexed max-heap
// Operation and status codes, datapath op codes and the status bundle that
// the datapath returns to the controller.
// ----------------------------------------------------------------------------
package imh_pkg;

    localparam int NUM_ENTRIES_DEF = 4096;
    localparam int PRI_BITS_DEF    = 16;

    localparam int ID_W    = 12;
    localparam int REQ_PRI_W = 16;
    localparam int KIND_W  = 2;
    localparam int STAT_W  = 2;
    localparam int FILL_W  = 13;
    localparam int TDATA_W = 32;

    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DELETE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

    localparam logic [STAT_W-1:0] ST_DONE    = 2'd0;
    localparam logic [STAT_W-1:0] ST_IGNORED = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY   = 2'd2;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_INIT,
        OP_IDLE,
        OP_INS_MAP,
        OP_INS_CHK,
        OP_DEL_TOP,
        OP_RM_START,
        OP_LOAD_LAST,
        OP_PUSH,
        OP_UP_RD,
        OP_UP_MOVE,
        OP_PLACE,
        OP_DN_RDL,
        OP_DN_L,
        OP_DN_R,
        OP_DN_MOVE,
        OP_CLR_STEP,
        OP_OUT
    } dp_op_t;

    typedef struct packed {
        logic              accept;
        logic [KIND_W-1:0] kind;
        logic              id_oob;
        logic              len_zero;
        logic              len_full;
        logic              init_last;
        logic              map_hit;
        logic              pri_higher;
        logic              slot_is_last;
        logic              slot_gt1;
        logic              parent_lower;
        logic              l_in;
        logic              r_in;
        logic              big_child;
        logic              clr_last;
        logic              out_free;
    } dp_stat_t;

endpackage

[src/imh_datapath.sv]
// ----------------------------------------------------------------------------
// imh_datapath: heap and position-map memories with working registers
// Executes one op per cycle as chosen by the controller; memory reads are
// registered and used in the following cycle.
// ----------------------------------------------------------------------------
module imh_datapath import imh_pkg::*; #(
    parameter int NUM_ENTRIES   = NUM_ENTRIES_DEF,
    parameter int PRIORITY_BITS = PRI_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  dp_op_t                op,
    output dp_stat_t              stat,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [KIND_W-1:0]     s_kind,
    input  logic [ID_W-1:0]       s_entry_id,
    input  logic [REQ_PRI_W-1:0]  s_priority_req,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [STAT_W-1:0]     m_status,
    output logic [ID_W-1:0]       m_removed_id,
    output logic [FILL_W-1:0]     m_fill_count
);

    localparam int SW = $clog2(NUM_ENTRIES + 1);
    localparam int IW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
    localparam int PB = PRIORITY_BITS;

    // heap slots 1..NUM_ENTRIES, slot 0 unused
    logic [ID_W-1:0] hid_mem  [NUM_ENTRIES+1];
    logic [PB-1:0]   hpri_mem [NUM_ENTRIES+1];
    logic [SW-1:0]   map_mem  [NUM_ENTRIES];

    logic            h_we;
    logic [SW-1:0]   h_waddr, h_raddr;
    logic [ID_W-1:0] h_wid;
    logic [PB-1:0]   h_wpri;
    logic            p_we;
    logic [IW-1:0]   p_waddr, p_raddr;
    logic [SW-1:0]   p_wdata;

    logic [ID_W-1:0] hid_rd_reg;
    logic [PB-1:0]   hpri_rd_reg;
    logic [SW-1:0]   map_rd_reg;

    logic [ID_W-1:0]   op_id_reg, item_id_reg, big_id_reg;
    logic [PB-1:0]     op_pri_reg, item_pri_reg, big_pri_reg;
    logic [SW-1:0]     slot_reg, len_reg, big_slot_reg, cnt_reg;
    logic              big_child_reg;
    logic [IW-1:0]     init_cnt_reg;
    logic [STAT_W-1:0] status_reg;
    logic [ID_W-1:0]   removed_reg;
    logic              m_tvalid_reg;
    logic [STAT_W-1:0] m_status_reg;
    logic [ID_W-1:0]   m_removed_reg;
    logic [FILL_W-1:0] m_fill_reg;

    logic            accept;
    logic [SW:0]     l_slot, r_slot;
    logic            out_free;

    assign s_tready = (op == OP_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign l_slot   = {slot_reg, 1'b0};
    assign r_slot   = {slot_reg, 1'b1};
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        stat              = '0;
        stat.accept       = accept;
        stat.kind         = s_kind;
        stat.id_oob       = 32'(s_entry_id) >= 32'(NUM_ENTRIES);
        stat.len_zero     = (len_reg == '0);
        stat.len_full     = (len_reg == SW'(NUM_ENTRIES));
        stat.init_last    = (init_cnt_reg == IW'(NUM_ENTRIES - 1));
        stat.map_hit      = (map_rd_reg != '0) && (map_rd_reg <= len_reg);
        stat.pri_higher   = (hpri_rd_reg > op_pri_reg);
        stat.slot_is_last = (slot_reg == len_reg);
        stat.slot_gt1     = (slot_reg > SW'(1));
        stat.parent_lower = (hpri_rd_reg < item_pri_reg);
        stat.l_in         = (l_slot <= {1'b0, len_reg});
        stat.r_in         = (r_slot <= {1'b0, len_reg});
        stat.big_child    = big_child_reg;
        stat.clr_last     = (cnt_reg == len_reg);
        stat.out_free     = out_free;
    end

    always_comb begin
        h_we    = 1'b0;
        h_waddr = slot_reg;
        h_wid   = item_id_reg;
        h_wpri  = item_pri_reg;
        h_raddr = '0;
        p_we    = 1'b0;
        p_waddr = '0;
        p_wdata = '0;
        p_raddr = '0;
        case (op)
            OP_INIT: begin
                p_we    = 1'b1;
                p_waddr = init_cnt_reg;
            end
            OP_IDLE: begin
                p_raddr = IW'(s_entry_id);
                h_raddr = SW'(1);
            end
            OP_INS_MAP: h_raddr = map_rd_reg;
            OP_INS_CHK: begin
                if (!stat.pri_higher) begin
                    p_we    = 1'b1;
                    p_waddr = IW'(op_id_reg);
                end
            end
            OP_DEL_TOP: begin
                p_we    = 1'b1;
                p_waddr = IW'(hid_rd_reg);
            end
            OP_RM_START: h_raddr = len_reg;
            OP_UP_RD:    h_raddr = slot_reg >> 1;
            OP_UP_MOVE: begin
                h_we    = 1'b1;
                h_wid   = hid_rd_reg;
                h_wpri  = hpri_rd_reg;
                p_we    = 1'b1;
                p_waddr = IW'(hid_rd_reg);
                p_wdata = slot_reg;
            end
            OP_PLACE: begin
                h_we    = 1'b1;
                p_we    = 1'b1;
                p_waddr = IW'(item_id_reg);
                p_wdata = slot_reg;
            end
            OP_DN_RDL: begin
                if (stat.l_in) begin
                    h_raddr = SW'(l_slot);
                end
            end
            OP_DN_L: begin
                if (stat.r_in) begin
                    h_raddr = SW'(r_slot);
                end
            end
            OP_DN_MOVE: begin
                h_we    = 1'b1;
                h_wid   = big_id_reg;
                h_wpri  = big_pri_reg;
                p_we    = 1'b1;
                p_waddr = IW'(big_id_reg);
                p_wdata = slot_reg;
            end
            OP_CLR_STEP: begin
                p_we    = 1'b1;
                p_waddr = IW'(hid_rd_reg);
                h_raddr = SW'(cnt_reg + SW'(1));
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (h_we) begin
            hid_mem[h_waddr]  <= h_wid;
            hpri_mem[h_waddr] <= h_wpri;
        end
        hid_rd_reg  <= hid_mem[h_raddr];
        hpri_rd_reg <= hpri_mem[h_raddr];
    end

    always_ff @(posedge aclk) begin
        if (p_we) begin
            map_mem[p_waddr] <= p_wdata;
        end
        map_rd_reg <= map_mem[p_raddr];
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            init_cnt_reg <= '0;
            len_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (op == OP_INIT) begin
                init_cnt_reg <= init_cnt_reg + IW'(1);
            end
            case (op)
                OP_RM_START: len_reg <= len_reg - SW'(1);
                OP_PUSH:     len_reg <= len_reg + SW'(1);
                OP_CLR_STEP: begin
                    if (stat.clr_last) begin
                        len_reg <= '0;
                    end
                end
                default: ;
            endcase
            if (op == OP_OUT && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        case (op)
            OP_IDLE: begin
                if (accept) begin
                    op_id_reg   <= s_entry_id;
                    op_pri_reg  <= PB'(s_priority_req);
                    removed_reg <= '0;
                    cnt_reg     <= SW'(1);
                    if (s_kind == KIND_INSERT && stat.id_oob) begin
                        status_reg <= ST_IGNORED;
                    end else if (s_kind == KIND_DELETE && stat.len_zero) begin
                        status_reg <= ST_EMPTY;
                    end else begin
                        status_reg <= ST_DONE;
                    end
                end
            end
            OP_INS_MAP: slot_reg <= map_rd_reg;
            OP_INS_CHK: begin
                if (stat.pri_higher) begin
                    status_reg <= ST_IGNORED;
                end
            end
            OP_DEL_TOP: begin
                removed_reg <= hid_rd_reg;
                slot_reg    <= SW'(1);
            end
            OP_LOAD_LAST: begin
                item_id_reg  <= hid_rd_reg;
                item_pri_reg <= hpri_rd_reg;
            end
            OP_PUSH: begin
                slot_reg     <= len_reg + SW'(1);
                item_id_reg  <= op_id_reg;
                item_pri_reg <= op_pri_reg;
            end
            OP_UP_MOVE: slot_reg <= slot_reg >> 1;
            OP_DN_L: begin
                if (hpri_rd_reg > item_pri_reg) begin
                    big_child_reg <= 1'b1;
                    big_slot_reg  <= SW'(l_slot);
                    big_id_reg    <= hid_rd_reg;
                    big_pri_reg   <= hpri_rd_reg;
                end else begin
                    big_child_reg <= 1'b0;
                    big_pri_reg   <= item_pri_reg;
                end
            end
            OP_DN_R: begin
                if (hpri_rd_reg > big_pri_reg) begin
                    big_child_reg <= 1'b1;
                    big_slot_reg  <= SW'(r_slot);
                    big_id_reg    <= hid_rd_reg;
                    big_pri_reg   <= hpri_rd_reg;
                end
            end
            OP_DN_MOVE: slot_reg <= big_slot_reg;
            OP_CLR_STEP: cnt_reg <= cnt_reg + SW'(1);
            default: ;
        endcase
        if (op == OP_OUT && out_free) begin
            m_status_reg  <= status_reg;
            m_removed_reg <= removed_reg;
            m_fill_reg    <= FILL_W'(len_reg);
        end
    end

    assign m_tvalid     = m_tvalid_reg;
    assign m_status     = m_status_reg;
    assign m_removed_id = m_removed_reg;
    assign m_fill_count = m_fill_reg;

endmodule

[src/imh_ctrl.sv]
// ----------------------------------------------------------------------------
// imh_ctrl: sequencing state machine for the indexed max-heap
// Walks map lookup, removal, sift up and sift down, and the clear sweep.
// ----------------------------------------------------------------------------
module imh_ctrl import imh_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  dp_stat_t stat,
    output dp_op_t   op
);

    typedef enum logic [15:0] {
        S_INIT     = 16'b0000000000000001,
        S_IDLE     = 16'b0000000000000010,
        S_INS_MAP  = 16'b0000000000000100,
        S_INS_CHK  = 16'b0000000000001000,
        S_DEL_TOP  = 16'b0000000000010000,
        S_RM_START = 16'b0000000000100000,
        S_RM_LAST  = 16'b0000000001000000,
        S_INS_PUSH = 16'b0000000010000000,
        S_UP       = 16'b0000000100000000,
        S_UP_CMP   = 16'b0000001000000000,
        S_DN       = 16'b0000010000000000,
        S_DN_L     = 16'b0000100000000000,
        S_DN_R     = 16'b0001000000000000,
        S_DN_DEC   = 16'b0010000000000000,
        S_CLR      = 16'b0100000000000000,
        S_DONE     = 16'b1000000000000000
    } state_t;

    typedef enum logic [1:0] {
        MODE_PUSH,
        MODE_RM_INS,
        MODE_RM_DEL
    } mode_t;

    state_t state_reg, state_next;
    mode_t  mode_reg, mode_next;
    state_t after_rm;
    state_t after_up;

    assign after_rm = (mode_reg == MODE_RM_INS) ? S_INS_PUSH : S_DONE;
    assign after_up = (mode_reg == MODE_PUSH) ? S_DONE : S_DN;

    always_comb begin
        state_next = state_reg;
        mode_next  = mode_reg;
        op         = OP_NONE;
        case (state_reg)
            S_INIT: begin
                op = OP_INIT;
                if (stat.init_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                op = OP_IDLE;
                if (stat.accept) begin
                    case (stat.kind)
                        KIND_INSERT: begin
                            state_next = stat.id_oob ? S_DONE : S_INS_MAP;
                        end
                        KIND_DELETE: state_next = stat.len_zero ? S_DONE : S_DEL_TOP;
                        KIND_CLEAR:  state_next = stat.len_zero ? S_DONE : S_CLR;
                        default:     state_next = S_DONE;
                    endcase
                end
            end
            S_INS_MAP: begin
                op         = OP_INS_MAP;
                mode_next  = MODE_RM_INS;
                state_next = stat.map_hit ? S_INS_CHK : S_INS_PUSH;
            end
            S_INS_CHK: begin
                op         = OP_INS_CHK;
                state_next = stat.pri_higher ? S_DONE : S_RM_START;
            end
            S_DEL_TOP: begin
                op         = OP_DEL_TOP;
                mode_next  = MODE_RM_DEL;
                state_next = S_RM_START;
            end
            S_RM_START: begin
                op         = OP_RM_START;
                state_next = stat.slot_is_last ? after_rm : S_RM_LAST;
            end
            S_RM_LAST: begin
                op         = OP_LOAD_LAST;
                state_next = S_UP;
            end
            S_INS_PUSH: begin
                if (stat.len_full) begin
                    state_next = S_DONE;
                end else begin
                    op         = OP_PUSH;
                    mode_next  = MODE_PUSH;
                    state_next = S_UP;
                end
            end
            S_UP: begin
                if (stat.slot_gt1) begin
                    op         = OP_UP_RD;
                    state_next = S_UP_CMP;
                end else begin
                    op         = OP_PLACE;
                    state_next = after_up;
                end
            end
            S_UP_CMP: begin
                if (stat.parent_lower) begin
                    op         = OP_UP_MOVE;
                    state_next = S_UP;
                end else begin
                    op         = OP_PLACE;
                    state_next = after_up;
                end
            end
            S_DN: begin
                if (stat.l_in) begin
                    op         = OP_DN_RDL;
                    state_next = S_DN_L;
                end else begin
                    op         = OP_PLACE;
                    state_next = after_rm;
                end
            end
            S_DN_L: begin
                op         = OP_DN_L;
                state_next = stat.r_in ? S_DN_R : S_DN_DEC;
            end
            S_DN_R: begin
                op         = OP_DN_R;
                state_next = S_DN_DEC;
            end
            S_DN_DEC: begin
                if (stat.big_child) begin
                    op         = OP_DN_MOVE;
                    state_next = S_DN;
                end else begin
                    op         = OP_PLACE;
                    state_next = after_rm;
                end
            end
            S_CLR: begin
                op = OP_CLR_STEP;
                if (stat.clr_last) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                op = OP_OUT;
                if (stat.out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_INIT;
            mode_reg  <= MODE_PUSH;
        end else begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
        end
    end

endmodule

[src/indexed_max_heap.sv]
// ----------------------------------------------------------------------------
// indexed_max_heap: binary max-heap of (id, priority) with a position map
//
//  channel | dir | tdata                                  | tuser
//  s_      | in  | [11:0] entry_id, [27:12] priority_req  | [1:0] kind
//  m_      | out | [11:0] removed_id, [24:12] fill_count  | [1:0] status
//
// One operation at a time. Insert: map lookup, push, then sift up level by
// level; a present id adds the removal first. Delete: removes the top, then
// sifts down, each level examined by two child reads on the single heap read
// port, decide, move. Clear: zeroes the map entry of each held entry in turn.
// After reset the position map is swept to zero with s_tready low. A new
// request is taken while a result waits on m_.
// ----------------------------------------------------------------------------
module indexed_max_heap import imh_pkg::*; #(
    parameter int NUM_ENTRIES   = NUM_ENTRIES_DEF,
    parameter int PRIORITY_BITS = PRI_BITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [TDATA_W-1:0] s_tdata,   // entry_id, priority_req
    input  logic [KIND_W-1:0]  s_tuser,   // kind
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,   // removed_id, fill_count
    output logic [STAT_W-1:0]  m_tuser    // status
);

    dp_op_t            op;
    dp_stat_t          stat;
    logic [ID_W-1:0]   m_removed_id;
    logic [FILL_W-1:0] m_fill_count;

    imh_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .stat    (stat),
        .op      (op)
    );

    imh_datapath #(
        .NUM_ENTRIES   (NUM_ENTRIES),
        .PRIORITY_BITS (PRIORITY_BITS)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .op             (op),
        .stat           (stat),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_kind         (s_tuser),
        .s_entry_id     (s_tdata[ID_W-1:0]),
        .s_priority_req (s_tdata[ID_W+REQ_PRI_W-1:ID_W]),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_status       (m_tuser),
        .m_removed_id   (m_removed_id),
        .m_fill_count   (m_fill_count)
    );

    assign m_tdata = {{(TDATA_W - ID_W - FILL_W){1'b0}}, m_fill_count, m_removed_id};

endmodule

[src/imh_checker.sv]
// ----------------------------------------------------------------------------
// imh_checker: port-level checks for indexed_max_heap
// Watches the result channel for held transfers and consistent fields.
// ----------------------------------------------------------------------------
module imh_checker import imh_pkg::*; #(
    parameter int NUM_ENTRIES = NUM_ENTRIES_DEF
) (
    input logic               aclk,
    input logic               aresetn,
    input logic               m_tvalid,
    input logic               m_tready,
    input logic [TDATA_W-1:0] m_tdata,
    input logic [STAT_W-1:0]  m_tuser
);

    // stalled transfer holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == ST_EMPTY |-> m_tdata[TDATA_W-1:0] == '0)
        else $error("empty delete reports nonzero id or fill");

    a_ignored: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == ST_IGNORED |-> m_tdata[ID_W-1:0] == '0)
        else $error("ignored insert reports a removed id");

    a_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> 32'(m_tdata[ID_W+FILL_W-1:ID_W]) <= 32'(NUM_ENTRIES))
        else $error("fill count above capacity");

endmodule

bind indexed_max_heap imh_checker #(.NUM_ENTRIES(NUM_ENTRIES)) u_imh_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for indexed_max_heap
// Drives insert, delete-max, clear and unused-kind ops over the s_
// stream with random gaps, keeps its own heap with a position map, and
// checks every m_ result (status, removed id, fill count) in order.
// ----------------------------------------------------------------------------
module tb;
    import imh_pkg::*;

    localparam int N = NUM_ENTRIES_DEF;
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [TDATA_W-1:0] s_tdata = '0;
    logic [KIND_W-1:0]  s_tuser = '0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [TDATA_W-1:0] m_tdata;
    logic [STAT_W-1:0]  m_tuser;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [ID_W-1:0]   removed_id;
        logic [FILL_W-1:0] fill_count;
    } heap_result_t;

    // predictor state
    logic [ID_W-1:0]      slot_id  [1:N];
    logic [REQ_PRI_W-1:0] slot_pri [1:N];
    int unsigned          where_is [0:N-1];
    int unsigned          fill;

    heap_result_t pending_results[$];
    int errors = 0;
    bit rx_enable = 1'b0;

    indexed_max_heap u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always #10 aclk = ~aclk;

    function automatic void put_slot(int unsigned s, logic [ID_W-1:0] id,
                                     logic [REQ_PRI_W-1:0] p);
        slot_id[s] = id;
        slot_pri[s] = p;
        where_is[id] = s;
    endfunction

    function automatic void climb(int unsigned s);
        logic [ID_W-1:0]      id;
        logic [REQ_PRI_W-1:0] p;
        id = slot_id[s];
        p = slot_pri[s];
        while (s > 1 && slot_pri[s/2] < p) begin
            put_slot(s, slot_id[s/2], slot_pri[s/2]);
            s = s / 2;
        end
        put_slot(s, id, p);
    endfunction

    function automatic void descend(int unsigned s);
        int unsigned big;
        logic [ID_W-1:0]      tid;
        logic [REQ_PRI_W-1:0] tp;
        forever begin
            big = s;
            if (2*s <= fill && slot_pri[2*s] > slot_pri[big]) big = 2*s;
            if (2*s+1 <= fill && slot_pri[2*s+1] > slot_pri[big]) big = 2*s+1;
            if (big == s) return;
            tid = slot_id[s];
            tp = slot_pri[s];
            put_slot(s, slot_id[big], slot_pri[big]);
            put_slot(big, tid, tp);
            s = big;
        end
    endfunction

    function automatic void take_out(int unsigned s);
        int unsigned last;
        logic [ID_W-1:0] moved;
        last = fill;
        where_is[slot_id[s]] = 0;
        fill = last - 1;
        if (s != last) begin
            moved = slot_id[last];
            put_slot(s, moved, slot_pri[last]);
            climb(s);
            descend(where_is[moved]);
        end
    endfunction

    function automatic heap_result_t heap_op(logic [KIND_W-1:0] kind, logic [ID_W-1:0] id,
                                             logic [REQ_PRI_W-1:0] p);
        heap_result_t r;
        int unsigned s;
        r = '0;
        r.status = ST_DONE;
        if (kind == KIND_INSERT) begin
            s = where_is[id];
            if (s != 0 && s <= fill && slot_pri[s] > p) begin
                r.status = ST_IGNORED;
            end else begin
                if (s != 0 && s <= fill) take_out(s);
                if (fill < N) begin
                    fill++;
                    put_slot(fill, id, p);
                    climb(fill);
                end
            end
        end else if (kind == KIND_DELETE) begin
            if (fill == 0) begin
                r.status = ST_EMPTY;
            end else begin
                r.removed_id = slot_id[1];
                take_out(1);
            end
        end else if (kind == KIND_CLEAR) begin
            for (int k = 1; k <= fill; k++) where_is[slot_id[k]] = 0;
            fill = 0;
        end
        r.fill_count = FILL_W'(fill);
        return r;
    endfunction

    // s_tvalid stays high after the transfer until a nonzero gap drops it
    task automatic send_op(logic [KIND_W-1:0] kind, logic [ID_W-1:0] id,
                           logic [REQ_PRI_W-1:0] p);
        int gap;
        gap = $urandom_range(0, 6);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= {4'd0, p, id};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_results.push_back(heap_op(kind, id, p));
        @(negedge aclk);
    endtask

    // result side: a random wait before each transfer
    initial begin : rx_ready
        int wait_cycles;
        wait (rx_enable);
        forever begin
            wait_cycles = $urandom_range(0, 6);
            if (wait_cycles != 0) begin
                m_tready <= 1'b0;
                repeat (wait_cycles) @(negedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!(m_tvalid && m_tready)) @(posedge aclk);
            @(negedge aclk);
        end
    end

    always @(posedge aclk) begin
        heap_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result transfer");
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (m_tuser !== want.status) begin
                    $error("status expected %0d got %0d", want.status, m_tuser);
                    errors++;
                end
                if (m_tdata[11:0] !== want.removed_id) begin
                    $error("removed_id expected %0d got %0d", want.removed_id, m_tdata[11:0]);
                    errors++;
                end
                if (m_tdata[24:12] !== want.fill_count) begin
                    $error("fill_count expected %0d got %0d", want.fill_count, m_tdata[24:12]);
                    errors++;
                end
            end
        end
    end

    task automatic test_directed();
        send_op(KIND_DELETE, 12'd0, 16'd0);        // empty heap
        send_op(KIND_INSERT, 12'd0, 16'd0);
        send_op(KIND_INSERT, 12'hFFF, 16'hFFFF);
        send_op(KIND_INSERT, 12'd5, 16'd100);
        send_op(KIND_INSERT, 12'd6, 16'd100);      // tie
        send_op(KIND_INSERT, 12'd5, 16'd50);       // lower: ignored
        send_op(KIND_INSERT, 12'd5, 16'd100);      // equal: replaced
        send_op(KIND_INSERT, 12'd6, 16'd200);      // raise
        send_op(KIND_INSERT, 12'hAAA, 16'h5555);
        send_op(KIND_INSERT, 12'h555, 16'hAAAA);
        send_op(KIND_UNUSED, 12'd1, 16'd1);
        for (int i = 0; i < 6; i++) send_op(KIND_DELETE, 12'hFFF, 16'hFFFF);
        send_op(KIND_INSERT, 12'd7, 16'd1);
        send_op(KIND_CLEAR, 12'd0, 16'd0);
        send_op(KIND_CLEAR, 12'd0, 16'd0);
        send_op(KIND_DELETE, 12'd0, 16'd0);
    endtask

    // small id pool so that repeats, raises and ignores are frequent
    task automatic test_random();
        int pick;
        logic [ID_W-1:0] id;
        for (int i = 0; i < 1000; i++) begin
            pick = $urandom_range(0, 99);
            id = ($urandom_range(0, 3) == 0) ? ID_W'($urandom) : ID_W'($urandom_range(0, 40));
            if (pick < 60)
                send_op(KIND_INSERT, id, ($urandom_range(0, 1) == 0) ?
                        REQ_PRI_W'($urandom) : REQ_PRI_W'($urandom_range(0, 15)));
            else if (pick < 95)
                send_op(KIND_DELETE, id, REQ_PRI_W'($urandom));
            else if (pick < 98)
                send_op(KIND_CLEAR, id, REQ_PRI_W'($urandom));
            else
                send_op(KIND_UNUSED, id, REQ_PRI_W'($urandom));
        end
    endtask

    initial begin
        for (int i = 0; i < N; i++) where_is[i] = 0;
        fill = 0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        rx_enable = 1'b1;
        test_directed();
        test_random();
        s_tvalid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (100) @(posedge aclk);
        if (errors == 0 && pending_results.size() == 0)
            $display("PASS indexed_max_heap");
        else
            $display("FAIL indexed_max_heap");
        $finish;
    end

    initial begin
        #20ms;
        $display("FAIL indexed_max_heap");
        $finish;
    end
endmodule

[files.f]
src/imh_pkg.sv
src/imh_datapath.sv
src/imh_ctrl.sv
src/indexed_max_heap.sv
src/imh_checker.sv
tb/tb.sv
